// File: rtl/pid_relay_temperature_control_assert.svh
// Assertion macros used by the checker of this block.
`ifndef PID_RELAY_TEMPERATURE_CONTROL_ASSERT_SVH
`define PID_RELAY_TEMPERATURE_CONTROL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/prc_pkg.sv
`default_nettype none
package prc_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int TEMP_W      = 16;
    localparam int ERROR_W     = 17;
    localparam int ISUM_W      = 19;
    localparam int INTEG_W     = 12;
    localparam int CTRL_W      = 40;

    localparam logic [CFG_INDEX_W-1:0] REG_SET_POINT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D    = 8'd3;

    // Stored integral stays within plus or minus 100 degree-seconds.
    localparam logic signed [ISUM_W-1:0] INTEG_MAX = 19'sd1600;
    localparam logic signed [ISUM_W-1:0] INTEG_MIN = -19'sd1600;

    typedef struct packed {
        logic signed [CFG_DATA_W-1:0] set_point;
        logic signed [CFG_DATA_W-1:0] gain_p;
        logic signed [CFG_DATA_W-1:0] gain_i;
        logic signed [CFG_DATA_W-1:0] gain_d;
    } t_cfg;

endpackage
`default_nettype wire

// File: rtl/prc_cfg_regs.sv
`default_nettype none
module prc_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [prc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [prc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output prc_pkg::t_cfg                        o_cfg
);
    import prc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SET_POINT: n_cfg.set_point = i_cfg_data;
                REG_GAIN_P:    n_cfg.gain_p    = i_cfg_data;
                REG_GAIN_I:    n_cfg.gain_i    = i_cfg_data;
                REG_GAIN_D:    n_cfg.gain_d    = i_cfg_data;
                default:       n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// File: rtl/prc_core.sv
`default_nettype none
module prc_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire prc_pkg::t_cfg                     i_cfg,
    input  wire logic                              i_step,
    input  wire logic signed [prc_pkg::TEMP_W-1:0] i_temperature,
    output logic signed [prc_pkg::CTRL_W-1:0]      o_control_value,
    output logic                                   o_relay_on
);
    import prc_pkg::*;

    logic signed [INTEG_W-1:0] r_integral;
    logic signed [INTEG_W-1:0] n_integral;
    logic signed [ERROR_W-1:0] r_prev_error;
    logic signed [ERROR_W-1:0] n_prev_error;

    logic signed [ERROR_W-1:0] err;
    logic signed [ISUM_W-1:0]  isum;
    logic signed [ERROR_W:0]   derr;
    logic signed [32:0]        prod_p;
    logic signed [34:0]        prod_i;
    logic signed [33:0]        prod_d;
    logic [CTRL_W-1:0]         ctl;

    always_comb begin
        err  = {i_cfg.set_point[CFG_DATA_W-1], i_cfg.set_point}
             - {i_temperature[TEMP_W-1], i_temperature};
        isum = {{(ISUM_W-INTEG_W){r_integral[INTEG_W-1]}}, r_integral}
             + {err[ERROR_W-1], err, 1'b0};
        derr = {err[ERROR_W-1], err} - {r_prev_error[ERROR_W-1], r_prev_error};

        prod_p = i_cfg.gain_p * err;
        prod_i = i_cfg.gain_i * isum;
        prod_d = i_cfg.gain_d * derr;

        // Proportional and integral products are in 2^-12 units, doubled to 2^-13.
        ctl = {{6{prod_p[32]}}, prod_p, 1'b0}
            + {{4{prod_i[34]}}, prod_i, 1'b0}
            + {{6{prod_d[33]}}, prod_d};

        // The clamp applies to the stored integral only, after the output is formed.
        priority if (isum > INTEG_MAX) begin
            n_integral = INTEG_MAX[INTEG_W-1:0];
        end else if (isum < INTEG_MIN) begin
            n_integral = INTEG_MIN[INTEG_W-1:0];
        end else begin
            n_integral = isum[INTEG_W-1:0];
        end
        n_prev_error = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral   <= '0;
            r_prev_error <= '0;
        end else if (i_step) begin
            r_integral   <= n_integral;
            r_prev_error <= n_prev_error;
        end
    end

    assign o_control_value = ctl;
    assign o_relay_on      = !ctl[CTRL_W-1] && (ctl != '0);

endmodule
`default_nettype wire

// File: rtl/pid_relay_temperature_control.sv
// PID heater controller with relay output. Each request on the sample stream carries
// a signed Q12.4 temperature in tdata and a sensor-fault flag in tuser. A good sample
// yields one registered result: the signed 40-bit control value in 2^-13 units in
// tdata and the relay flag (control value above zero) in tuser. A
// faulted sample is dropped without a result and leaves the integral and the stored
// error untouched. One sample is taken per cycle when the result side keeps up; the
// rate is set by the combinational error, three-multiply and add path in prc_core,
// which also updates the state. Configuration writes are always ready; indexes above
// 3 are ignored. Registers: 0 setpoint (Q12.4), 1 to 3 the P, I and D gains (Q8.8).
`default_nettype none
module pid_relay_temperature_control (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [15:0]                     i_s_axis_tdata,  // [15:0] temperature
    input  wire logic [0:0]                      i_s_axis_tuser,  // [0] sensor_fault
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic [39:0]                          o_m_axis_tdata,  // [39:0] control_value
    output logic [0:0]                           o_m_axis_tuser,  // [0] relay_on
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [prc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [prc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import prc_pkg::*;

    t_cfg cfg;

    logic                     r_in_valid;
    logic                     n_in_valid;
    logic signed [TEMP_W-1:0] r_in_temp;
    logic                     r_in_fault;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [CTRL_W-1:0]        r_out_data;
    logic                     r_out_relay;

    logic                     s_accept;
    logic                     out_free;
    logic                     in_move;
    logic                     step;
    logic signed [CTRL_W-1:0] core_ctl;
    logic                     core_relay;

    assign o_cfg_ready = 1'b1;

    prc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign in_move         = r_in_valid && (r_in_fault || out_free);
    assign step            = r_in_valid && !r_in_fault && out_free;
    assign o_s_axis_tready = !r_in_valid || in_move;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    prc_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_step          (step),
        .i_temperature   (r_in_temp),
        .o_control_value (core_ctl),
        .o_relay_on      (core_relay)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (s_accept) begin
            n_in_valid = 1'b1;
        end else if (in_move) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = out_free ? step : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_temp  <= i_s_axis_tdata;
            r_in_fault <= i_s_axis_tuser[0];
        end
        if (step) begin
            r_out_data  <= core_ctl;
            r_out_relay <= core_relay;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_relay;

endmodule
`default_nettype wire

// File: rtl/prc_checker.sv
`default_nettype none
`include "pid_relay_temperature_control_assert.svh"
module prc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [0:0]  i_s_axis_tuser,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [39:0] o_m_axis_tdata,
    input wire logic [0:0]  o_m_axis_tuser
);

    // A result that waits must hold its value.
    `PRC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result changed")

    // The relay flag follows the sign of the control value.
    `PRC_ASSERT_IMP(a_relay_sign, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tuser[0] == (!o_m_axis_tdata[39] && (o_m_axis_tdata != 40'd0)), "relay flag disagrees with control value")

    // A result appearing on an empty output comes from a good sample that went straight through the input register.
    `PRC_ASSERT_IMP(a_result_source, i_clk, i_rst_n, $rose(o_m_axis_tvalid), $past(i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser[0], 2), "result without a good sample")

endmodule

bind pid_relay_temperature_control prc_checker u_prc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire
